/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

/* rtl/occ_pkg.sv */
package occ_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int COUNT_WIDTH  = 16;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NUM_W        = COUNT_WIDTH + 1;
  localparam int WIDE_W       = COUNT_WIDTH + 2;
  localparam int STEP_W       = $clog2(NUM_W);

  localparam int REQ_W        = 2;
  localparam int CHAN_W       = 2;
  localparam int PERIOD_W     = 16;
  localparam int MASK_W       = 4;
  localparam int READBACK_W   = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int WAKE_W       = 8;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 24;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [WIDE_W-1:0]      wide_t;

  localparam count_t OFF_CODE = '1;
  localparam logic [PERIOD_W-1:0] PERIOD_OFF = 16'hFFFF;
  localparam logic [READBACK_W-1:0] READBACK_NONE = 16'hFFFF;

  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODULO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEAD_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAKE_LEAD     = 2'd2;

  localparam logic [CFG_W-1:0]  WRAP_MODULO_RESET   = 16'd65534;
  localparam logic [CFG_W-1:0]  MIN_LEAD_TIME_RESET = 16'd50;
  localparam logic [WAKE_W-1:0] WAKE_LEAD_RESET     = 8'd5;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [CHAN_W-1:0]   channel;
    logic [PERIOD_W-1:0] period_value;
  } occ_item_t;

  typedef struct packed {
    logic [MASK_W-1:0]     match_mask;
    logic                  enough_time;
    logic [READBACK_W-1:0] compare_readback;
  } occ_result_t;

  typedef struct packed {
    logic             need;
    logic [NUM_W-1:0] numerator;
    count_t           modulus;
  } occ_slow_t;

  typedef struct packed {
    logic start;
    logic ack;
  } occ_mod_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } occ_mod_status_t;

endpackage

/* rtl/occ_mod_unit.sv */
`include "assert_macros.svh"

module occ_mod_unit
  import occ_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  occ_mod_ctrl_t    ctrl,
  input  logic [NUM_W-1:0] numerator,
  input  count_t           modulus,
  output occ_mod_status_t  status,
  output count_t           remainder
);

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t           state;
  logic [NUM_W-1:0] num;
  count_t           rem;
  logic [STEP_W-1:0] step;

  logic [COUNT_WIDTH:0] trial;
  logic [COUNT_WIDTH:0] mod_ext;
  count_t               rem_next;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial    = {rem, num[NUM_W-1]};
    mod_ext  = {1'b0, modulus};
    rem_next = (trial >= mod_ext) ? COUNT_WIDTH'(trial - mod_ext) : COUNT_WIDTH'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (ctrl.start) begin
            num   <= numerator;
            rem   <= '0;
            step  <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          num  <= num << 1;
          rem  <= rem_next;
          step <= step + 1'b1;
          if (step == STEP_W'(NUM_W - 1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (ctrl.ack) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign status.idle = (state == IDLE);
  assign status.done = (state == DONE);
  assign remainder   = rem;

  `ASSERT_NEVER(a_start_when_busy, clk, rst, ctrl.start && state != IDLE)
  `ASSERT_PROP(a_last_step_done, clk, rst,
    (state == RUN && step == STEP_W'(NUM_W - 1)) |=> (state == DONE))
  `ASSERT_PROP(a_rem_below_mod, clk, rst, (state == DONE) |-> (rem < modulus))

endmodule

/* rtl/occ_core.sv */
module occ_core
  import occ_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  occ_item_t            item,
  input  logic                 commit,
  input  count_t               mod_rem,
  output occ_slow_t            slow,
  output occ_result_t          result
);

  logic [CFG_W-1:0]  wrap_modulo;
  logic [CFG_W-1:0]  min_lead_time;
  logic [WAKE_W-1:0] wake_lead;
  count_t            tick_counter;
  count_t            compare_values [NUM_CHANNELS];

  logic                ch_valid;
  logic [CH_IDX_W-1:0] ch_idx;
  count_t              cur_cmp;
  count_t              counter_tick;
  wide_t               num;
  wide_t               modw;
  wide_t               diff;
  count_t              fast_val;
  logic                need_slow;
  count_t              set_val;
  logic signed [WIDE_W-1:0] lead;
  logic                enough;
  logic [MASK_W-1:0]   mask;

  always_comb begin
    ch_valid = (32'(item.channel) < NUM_CHANNELS);
    ch_idx   = CH_IDX_W'(item.channel);
    cur_cmp  = ch_valid ? compare_values[ch_idx] : OFF_CODE;

    if (wide_t'(tick_counter) >= wide_t'(wrap_modulo)) begin
      counter_tick = '0;
    end else begin
      counter_tick = tick_counter + 1'b1;
    end

    mask = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (i < MASK_W && compare_values[i] != OFF_CODE && compare_values[i] == counter_tick) begin
        mask[i] = 1'b1;
      end
    end

    // An off channel wakes relative to the counter, an active one steps by its period.
    if (cur_cmp == OFF_CODE) begin
      num = wide_t'(tick_counter) + wide_t'(wake_lead);
    end else begin
      num = wide_t'(cur_cmp) + wide_t'(item.period_value);
    end
    modw      = wide_t'(wrap_modulo);
    diff      = num - modw;
    need_slow = 1'b0;
    if (wrap_modulo == '0) begin
      fast_val = num[COUNT_WIDTH-1:0];
    end else if (num < modw) begin
      fast_val = num[COUNT_WIDTH-1:0];
    end else if (diff < modw) begin
      fast_val = diff[COUNT_WIDTH-1:0];
    end else begin
      fast_val  = num[COUNT_WIDTH-1:0];
      need_slow = 1'b1;
    end
    if (item.period_value == PERIOD_OFF) begin
      need_slow = 1'b0;
      set_val   = OFF_CODE;
    end else begin
      set_val   = need_slow ? mod_rem : fast_val;
    end

    // Forward distance from counter to compare across the wrap; may go negative.
    if (cur_cmp < tick_counter) begin
      lead = $signed(modw) - $signed(wide_t'(tick_counter)) + $signed(wide_t'(cur_cmp));
    end else begin
      lead = $signed(wide_t'(cur_cmp)) - $signed(wide_t'(tick_counter));
    end
    enough = ch_valid && (cur_cmp != tick_counter) &&
             (lead > $signed(wide_t'(min_lead_time)));

    slow.need      = (item.req_type == REQ_SET) && ch_valid && need_slow;
    slow.numerator = num[NUM_W-1:0];
    slow.modulus   = COUNT_WIDTH'(wrap_modulo);

    result.match_mask  = (item.req_type == REQ_TICK) ? mask : '0;
    result.enough_time = (item.req_type == REQ_QUERY) && enough;
    if (!ch_valid) begin
      result.compare_readback = READBACK_NONE;
    end else if (item.req_type == REQ_SET) begin
      result.compare_readback = READBACK_W'(set_val);
    end else begin
      result.compare_readback = READBACK_W'(cur_cmp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_modulo   <= WRAP_MODULO_RESET;
      min_lead_time <= MIN_LEAD_TIME_RESET;
      wake_lead     <= WAKE_LEAD_RESET;
      tick_counter  <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        compare_values[i] <= OFF_CODE;
      end
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_WRAP_MODULO:   wrap_modulo   <= cfg_data;
          REG_MIN_LEAD_TIME: min_lead_time <= cfg_data;
          REG_WAKE_LEAD:     wake_lead     <= cfg_data[WAKE_W-1:0];
          default: begin
          end
        endcase
      end
      if (commit) begin
        if (item.req_type == REQ_TICK) begin
          tick_counter <= counter_tick;
        end else if (item.req_type == REQ_SET && ch_valid) begin
          compare_values[ch_idx] <= set_val;
        end
      end
    end
  end

endmodule

/* rtl/output_compare_channel_scheduler.sv */
// Four-channel output-compare scheduler. It takes one word per clock when
// not stalled and returns one word per input word, through the input stage
// register and then the output register. The exception is a set word whose
// advanced compare lands at or beyond twice the wrap modulus: its remainder
// comes from an iterative unit that produces one bit per cycle, and that word
// holds the input stage until the remainder is done. All other words, every
// tick and query included, sustain one per cycle when the output is not
// stalled. The output register lets a new word enter while a finished word waits.
`include "assert_macros.svh"

module output_compare_channel_scheduler
  import occ_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // channel, period_value, zero pad
  input  logic [REQ_W-1:0]       s_axis_tuser,   // req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // match_mask, enough_time,
                                                 // compare_readback, zero pad
);

  occ_item_t       in_item;
  occ_item_t       s1_item;
  logic            s1_valid;
  occ_result_t     result;
  occ_result_t     out_data;
  logic            out_valid;
  occ_slow_t       slow;
  occ_mod_ctrl_t   mod_ctrl;
  occ_mod_status_t mod_status;
  count_t          mod_rem;
  logic            commit;

  assign in_item.req_type     = s_axis_tuser;
  assign in_item.channel      = s_axis_tdata[CHAN_W-1:0];
  assign in_item.period_value = s_axis_tdata[CHAN_W+PERIOD_W-1:CHAN_W];

  assign commit = s1_valid && (!slow.need || mod_status.done) &&
                  (!out_valid || m_axis_tready);
  assign s_axis_tready  = !s1_valid || commit;
  assign mod_ctrl.start = s1_valid && slow.need && mod_status.idle;
  assign mod_ctrl.ack   = commit && slow.need;

  occ_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (s1_item),
    .commit    (commit),
    .mod_rem   (mod_rem),
    .slow      (slow),
    .result    (result)
  );

  occ_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mod_ctrl),
    .numerator (slow.numerator),
    .modulus   (slow.modulus),
    .status    (mod_status),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        s1_valid <= 1'b1;
        s1_item  <= in_item;
      end else if (commit) begin
        s1_valid <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
        out_data  <= result;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'({out_data.compare_readback, out_data.enough_time,
                                       out_data.match_mask});

  `ASSERT_PROP(a_slow_item_held, clk, rst,
    (s1_valid && slow.need && !mod_status.done) |=> s1_valid)
  `ASSERT_PROP(a_commit_shows, clk, rst, commit |=> m_axis_tvalid)
  `ASSERT_PROP(a_mod_released, clk, rst, (commit && slow.need) |=> mod_status.idle)

endmodule
